[rtl/cna_pkg.sv]
// ----------------------------------------------------------------------------
// cna_pkg
// Shared types and codes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cna_pkg;

   localparam int IO_BITS = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [IO_BITS-1:0] a_real;
      logic signed [IO_BITS-1:0] a_imag;
      logic signed [IO_BITS-1:0] b_real;
      logic signed [IO_BITS-1:0] b_imag;
   } req_type;

   typedef struct packed {
      logic signed [IO_BITS-1:0] res_real;
      logic signed [IO_BITS-1:0] res_imag;
      logic [1:0]                status;
   } rsp_type;

endpackage

[rtl/complex_number_alu.sv]
// ----------------------------------------------------------------------------
// complex_number_alu
// Complex add, subtract, multiply and divide on signed fixed-point words.
// ----------------------------------------------------------------------------
// Usage: present op and operands on req_* with req_valid; a transfer happens
// when req_valid and req_ready are both high. Each transfer yields exactly
// one result on rsp_* (real, imaginary, status), in order.
// The path is the same for every op, so results leave in order: 2 product
// stages, one cell per numerator bit of the divider chain, and the output
// register. Throughput is one item per cycle while the output is not held:
// the whole datapath is a pipeline of registers, the divider a chain of
// restoring-division cells, one quotient bit per cell.
// While a result waits on rsp_ready the whole pipeline holds. A one-entry
// skid register takes a transfer offered in that cycle; req_ready is low
// while it is occupied, and an item that waits there adds the stall time.
// Reset clears the valid bits only; no clearing pass is needed.
// Status: 0 ok, 1 saturated, 2 divide by zero (result zero).
// ----------------------------------------------------------------------------
module complex_number_alu
   import cna_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int EW  = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 16) ? 16 : WORD_BITS);
   localparam int EF  = (FRAC_BITS > 30) ? 30 : ((FRAC_BITS < 1) ? 1 : FRAC_BITS);
   localparam int MB  = 2 * EW + 1;      // magnitude bits
   localparam int NB  = MB + EF;         // numerator bits
   localparam int DB  = 2 * EW;          // divisor bits
   localparam int QB  = 42;              // quotient, saturating at 2^41
   localparam int LAT = NB + 3;

   logic    out_vld_ff;
   rsp_type out_ff;
   logic    en;
   logic    accept;
   logic    skid_vld_ff;
   req_type skid_ff;
   logic    in_vld;
   req_type in_data;

   // pipeline advances unless a result is waiting
   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = !skid_vld_ff;
   assign accept    = req_valid && req_ready;
   assign in_vld    = skid_vld_ff || accept;
   assign in_data   = skid_vld_ff ? skid_ff : req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (en) begin
         skid_vld_ff <= 1'b0;
      end else if (accept) begin
         skid_vld_ff <= 1'b1;
      end
      if (!en && accept) begin
         skid_ff <= req_data;
      end
   end

   logic signed [EW-1:0] ar, ai, br, bi;
   assign ar = in_data.a_real[EW-1:0];
   assign ai = in_data.a_imag[EW-1:0];
   assign br = in_data.b_real[EW-1:0];
   assign bi = in_data.b_imag[EW-1:0];

   // control pipeline: valid and op alongside the datapath
   logic [LAT-2:0] vld_ff;
   logic [1:0]     op_d1_ff, op_d2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-3:0], in_vld};
      end
      if (en) begin
         op_d1_ff <= in_data.op;
         op_d2_ff <= op_d1_ff;
      end
   end

   logic signed [65:0] sum_re, sum_im;
   logic [NB-1:0]      num_re, num_im;
   logic               neg_re, neg_im, den_zero;
   logic [DB-1:0]      den;

   cna_front #(.EW(EW), .EF(EF), .NB(NB), .DB(DB)) u_front (
      .clock, .en, .op(in_data.op), .ar, .ai, .br, .bi,
      .sum_re, .sum_im, .num_re, .num_im, .neg_re, .neg_im, .den, .den_zero
   );

   // saturation of sum/product results (stage 2 values)
   logic signed [65:0] prod_re, prod_im;
   logic signed [EW-1:0] ws_re, ws_im;
   logic                 fs_re, fs_im;
   localparam logic signed [65:0] HI = 66'((66'sd1 <<< (EW - 1)) - 1);
   localparam logic signed [65:0] LO = 66'(-(66'sd1 <<< (EW - 1)));

   always_comb begin
      if (op_d2_ff == OP_MUL) begin
         prod_re = sum_re >>> EF;
         prod_im = sum_im >>> EF;
      end else begin
         prod_re = sum_re;
         prod_im = sum_im;
      end
      fs_re = (prod_re > HI) || (prod_re < LO);
      fs_im = (prod_im > HI) || (prod_im < LO);
      ws_re = (prod_re > HI) ? EW'(HI) : ((prod_re < LO) ? EW'(LO) : EW'(prod_re));
      ws_im = (prod_im > HI) ? EW'(HI) : ((prod_im < LO) ? EW'(LO) : EW'(prod_im));
   end

   // side pipe for non-divide results, flags and op across the divider chain
   typedef struct packed {
      logic [1:0]    op;
      logic [EW-1:0] re;
      logic [EW-1:0] im;
      logic          fre;
      logic          fim;
      logic          nre;
      logic          nim;
      logic          dz;
   } side_type;

   side_type side_ff [NB];
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= '{op: op_d2_ff, re: ws_re, im: ws_im, fre: fs_re, fim: fs_im,
                         nre: neg_re, nim: neg_im, dz: den_zero};
         for (int k = 1; k < NB; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // divider chains, one cell per numerator bit
   logic [DB:0]   rr [NB+1], ri [NB+1];
   logic [NB-1:0] nr [NB+1], ni [NB+1];
   logic [DB-1:0] dr [NB+1], di [NB+1];
   logic [QB-1:0] qr [NB+1], qi [NB+1];

   assign rr[0] = '0;
   assign ri[0] = '0;
   assign nr[0] = num_re;
   assign ni[0] = num_im;
   assign dr[0] = den;
   assign di[0] = den;
   assign qr[0] = '0;
   assign qi[0] = '0;

   for (genvar g = 0; g < NB; g++) begin : g_cell
      cna_div_cell #(.NB(NB), .DB(DB), .QB(QB)) u_re (
         .clock, .en, .r_i(rr[g]), .n_i(nr[g]), .d_i(dr[g]), .q_i(qr[g]),
         .r_o(rr[g+1]), .n_o(nr[g+1]), .d_o(dr[g+1]), .q_o(qr[g+1])
      );
      cna_div_cell #(.NB(NB), .DB(DB), .QB(QB)) u_im (
         .clock, .en, .r_i(ri[g]), .n_i(ni[g]), .d_i(di[g]), .q_i(qi[g]),
         .r_o(ri[g+1]), .n_o(ni[g+1]), .d_o(di[g+1]), .q_o(qi[g+1])
      );
   end

   // final select and saturation
   side_type           sl;
   logic signed [43:0] qv_re, qv_im;
   logic               fq_re, fq_im;
   logic [EW-1:0]      wq_re, wq_im;
   localparam logic signed [43:0] HQ = 44'(HI);
   localparam logic signed [43:0] LQ = 44'(LO);
   rsp_type            res;

   assign sl = side_ff[NB-1];

   always_comb begin
      qv_re = sl.nre ? -44'(qr[NB]) : 44'(qr[NB]);
      qv_im = sl.nim ? -44'(qi[NB]) : 44'(qi[NB]);
      fq_re = (qv_re > HQ) || (qv_re < LQ);
      fq_im = (qv_im > HQ) || (qv_im < LQ);
      wq_re = (qv_re > HQ) ? EW'(HQ) : ((qv_re < LQ) ? EW'(LQ) : EW'(qv_re));
      wq_im = (qv_im > HQ) ? EW'(HQ) : ((qv_im < LQ) ? EW'(LQ) : EW'(qv_im));
      res = '0;
      if (sl.op == OP_DIV) begin
         if (sl.dz) begin
            res.status = ST_DIV0;
         end else begin
            res.res_real = IO_BITS'($signed(wq_re));
            res.res_imag = IO_BITS'($signed(wq_im));
            res.status   = (fq_re || fq_im) ? ST_SAT : ST_OK;
         end
      end else begin
         res.res_real = IO_BITS'($signed(sl.re));
         res.res_imag = IO_BITS'($signed(sl.im));
         res.status   = (sl.fre || sl.fim) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[LAT-2];
      end
      if (en) begin
         out_ff <= res;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while waiting");
   a_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && !en) |=> skid_vld_ff)
      else $error("stalled transfer not held in skid register");
   a_div0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_DIV0) |->
      (rsp_data.res_real == '0 && rsp_data.res_imag == '0))
      else $error("divide by zero result not zero");
`endif
endmodule

[rtl/cna_div_cell.sv]
// ----------------------------------------------------------------------------
// cna_div_cell
// One restoring-division stage: shifts in a numerator bit, trial subtract.
// ----------------------------------------------------------------------------
module cna_div_cell #(
   parameter int NB = 72,
   parameter int DB = 64,
   parameter int QB = 42
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DB:0]   r_i,
   input  logic [NB-1:0] n_i,
   input  logic [DB-1:0] d_i,
   input  logic [QB-1:0] q_i,
   output logic [DB:0]   r_o,
   output logic [NB-1:0] n_o,
   output logic [DB-1:0] d_o,
   output logic [QB-1:0] q_o
);
   logic [DB+1:0] r_sh;
   logic [DB+1:0] diff;
   logic          ge;
   logic [DB:0]   r_ff;
   logic [NB-1:0] n_ff;
   logic [DB-1:0] d_ff;
   logic [QB-1:0] q_ff;

   assign r_sh = {r_i, n_i[NB-1]};
   assign diff = r_sh - {2'b00, d_i};
   assign ge   = !diff[DB+1];

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= ge ? diff[DB:0] : r_sh[DB:0];
         n_ff <= {n_i[NB-2:0], 1'b0};
         d_ff <= d_i;
         // quotient saturates once its top bit is reached
         q_ff <= q_i[QB-1] ? q_i : {q_i[QB-2:0], ge};
      end
   end

   assign r_o = r_ff;
   assign n_o = n_ff;
   assign d_o = d_ff;
   assign q_o = q_ff;
endmodule

[rtl/cna_front.sv]
// ----------------------------------------------------------------------------
// cna_front
// Operand products and sums; sets up magnitude and divisor for the divider.
// ----------------------------------------------------------------------------
module cna_front
   import cna_pkg::*;
#(
   parameter int EW = 32,
   parameter int EF = 16,
   parameter int NB = 96,
   parameter int DB = 64
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [1:0]           op,
   input  logic signed [EW-1:0] ar,
   input  logic signed [EW-1:0] ai,
   input  logic signed [EW-1:0] br,
   input  logic signed [EW-1:0] bi,
   output logic signed [65:0]   sum_re,
   output logic signed [65:0]   sum_im,
   output logic [NB-1:0]        num_re,
   output logic [NB-1:0]        num_im,
   output logic                 neg_re,
   output logic                 neg_im,
   output logic [DB-1:0]        den,
   output logic                 den_zero
);
   // stage 1: four products, and the operand sum or difference
   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [65:0] add_re_ff, add_im_ff;
   logic [1:0]         op_ff;
   logic signed [65:0] s_re, s_im;
   logic [65:0]        m_re, m_im;
   logic [DB-1:0]      den_w;

   always_ff @(posedge clock) begin
      if (en) begin
         p_rr_ff <= 64'(ar * br);
         p_ii_ff <= 64'(ai * bi);
         p_ri_ff <= 64'(ar * bi);
         p_ir_ff <= 64'(ai * br);
         op_ff   <= op;
         if (op == OP_ADD) begin
            add_re_ff <= 66'(ar) + 66'(br);
            add_im_ff <= 66'(ai) + 66'(bi);
         end else begin
            add_re_ff <= 66'(ar) - 66'(br);
            add_im_ff <= 66'(ai) - 66'(bi);
         end
      end
   end

   always_comb begin
      case (op_ff)
         OP_MUL: begin
            s_re = 66'(p_rr_ff) - 66'(p_ii_ff);
            s_im = 66'(p_ri_ff) + 66'(p_ir_ff);
         end
         OP_DIV: begin
            s_re = 66'(p_rr_ff) + 66'(p_ii_ff);
            s_im = 66'(p_ir_ff) - 66'(p_ri_ff);
         end
         default: begin
            s_re = add_re_ff;
            s_im = add_im_ff;
         end
      endcase
      m_re = s_re[65] ? 66'(-s_re) : s_re;
      m_im = s_im[65] ? 66'(-s_im) : s_im;
   end

   // divisor squares: a second product stage
   logic signed [63:0] sq_r_ff, sq_i_ff;
   logic signed [EW-1:0] br_ff, bi_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         br_ff <= br;
         bi_ff <= bi;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sq_r_ff <= 64'(br_ff * br_ff);
         sq_i_ff <= 64'(bi_ff * bi_ff);
      end
   end
   assign den_w = DB'(sq_r_ff) + DB'(sq_i_ff);

   // stage 2 outputs, registered to line up with the squares
   logic signed [65:0] s_re_ff, s_im_ff;
   logic [NB-1:0]      num_re_ff, num_im_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s_re_ff   <= s_re;
         s_im_ff   <= s_im;
         num_re_ff <= {m_re[NB-EF-1:0], {EF{1'b0}}};
         num_im_ff <= {m_im[NB-EF-1:0], {EF{1'b0}}};
      end
   end

   assign sum_re   = s_re_ff;
   assign sum_im   = s_im_ff;
   assign num_re   = num_re_ff;
   assign num_im   = num_im_ff;
   assign neg_re   = s_re_ff[65];
   assign neg_im   = s_im_ff[65];
   assign den      = den_w;
   assign den_zero = (den_w == '0);
endmodule
